// ----- src/vdws_pkg.sv -----
// vdws_pkg: shared types, constants and the sine table builder for the vertex distort block
// no dependencies; imported by every module under src

package vdws_pkg;

    localparam int SINE_DEPTH_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;

    // odd polynomial coefficients of the quarter-wave sine, Q30
    localparam longint unsigned K_C1 = 64'd1686629713;
    localparam longint unsigned K_C3 = 64'd693598668;
    localparam longint unsigned K_C5 = 64'd85569305;
    localparam longint unsigned K_C7 = 64'd5026995;
    localparam longint unsigned K_C9 = 64'd172273;
    localparam longint unsigned Q30  = 64'd1 << 30;

    typedef enum logic [2:0] {
        REG_WAVE   = 3'd0,
        REG_SQUASH = 3'd1,
        REG_SCALE  = 3'd2,
        REG_MIN_Y  = 3'd3,
        REG_MIN_Z  = 3'd4,
        REG_MAX_Z  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } t_vtx;

    typedef struct packed {
        logic wave_on;
        logic wave_term_on;
        logic squash_on;
        logic scale_on;
    } t_cfg_flags;

    // table entry k of a 2**log_d entry full-turn sine, fb fraction bits
    function automatic longint sine_entry(longint unsigned k, int log_d, int fb);
        longint unsigned t, q, r, u, u2, h, s, m;
        t  = (k << 32) >> log_d;
        q  = (t >> 30) & 64'd3;
        r  = t & (Q30 - 64'd1);
        u  = q[0] ? (Q30 - r) : r;
        u2 = (u * u) >> 30;
        h  = K_C7 - ((u2 * K_C9) >> 30);
        h  = K_C5 - ((u2 * h) >> 30);
        h  = K_C3 - ((u2 * h) >> 30);
        h  = K_C1 - ((u2 * h) >> 30);
        s  = (u * h) >> 30;
        m  = (s + (64'd1 << (29 - fb))) >> (30 - fb);
        return (q >= 64'd2) ? -longint'(m) : longint'(m);
    endfunction

    // saturate a signed value to 32 bits
    function automatic logic signed [31:0] sat32(longint v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ----- src/vdws_sine_rom.sv -----
// vdws_sine_rom: full-turn sine lookup with registered read
// depends on vdws_pkg for the entry builder

module vdws_sine_rom #(
    parameter int SINE_TABLE_DEPTH = vdws_pkg::SINE_DEPTH_DEF,
    parameter int FRACTION_BITS    = vdws_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]   i_addr,
    output logic signed [FRACTION_BITS+1:0]       o_data
);
    import vdws_pkg::*;

    localparam int LOG_D = $clog2(SINE_TABLE_DEPTH);
    localparam int SW    = FRACTION_BITS + 2;

    typedef logic signed [SW-1:0] t_rom_tab [SINE_TABLE_DEPTH];

    function automatic t_rom_tab build_tab();
        t_rom_tab tab;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            tab[k] = SW'(sine_entry(longint'(k), LOG_D, FRACTION_BITS));
        end
        return tab;
    endfunction

    localparam t_rom_tab TAB = build_tab();

    logic signed [SW-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= TAB[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ----- src/vdws_phase_div.sv -----
// vdws_phase_div: pipelined restoring divider, one quotient bit per stage, for the wave phase
// depends on vdws_pkg for the vertex struct

module vdws_phase_div #(
    parameter int SINE_TABLE_DEPTH = vdws_pkg::SINE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  vdws_pkg::t_vtx                      i_vtx,
    input  logic [31:0]                         i_zr,
    output logic                                o_vld,
    output logic [$clog2(SINE_TABLE_DEPTH)-1:0] o_q,
    output vdws_pkg::t_vtx                      o_vtx
);
    import vdws_pkg::*;

    localparam int LOG_D = $clog2(SINE_TABLE_DEPTH);
    localparam int SH    = LOG_D - 2;       // |z|*D/(4*zr) = (|z| << SH) / zr
    localparam int NW    = 32 + SH;         // dividend bits, one stage each

    logic             r_vld [NW];
    logic [31:0]      r_rem [NW];
    logic [LOG_D-1:0] r_q   [NW];
    logic [31:0]      r_abs [NW];
    t_vtx             r_vtx [NW];

    logic [31:0] in_abs;
    assign in_abs = i_vtx.z[31] ? (~i_vtx.z + 32'd1) : i_vtx.z;

    for (genvar i = 0; i < NW; i++) begin : g_stage
        localparam int J = NW - 1 - i;
        logic             p_vld;
        logic [31:0]      p_rem;
        logic [LOG_D-1:0] p_q;
        logic [31:0]      p_abs;
        t_vtx             p_vtx;
        logic             dbit;
        logic [32:0]      rem_sh;
        logic [32:0]      rem_sub;
        logic             qbit;

        if (i == 0) begin : g_first
            assign p_vld = i_vld;
            assign p_rem = '0;
            assign p_q   = '0;
            assign p_abs = in_abs;
            assign p_vtx = i_vtx;
        end else begin : g_next
            assign p_vld = r_vld[i-1];
            assign p_rem = r_rem[i-1];
            assign p_q   = r_q[i-1];
            assign p_abs = r_abs[i-1];
            assign p_vtx = r_vtx[i-1];
        end

        if (J >= SH) begin : g_bit
            assign dbit = p_abs[J-SH];
        end else begin : g_zero
            assign dbit = 1'b0;
        end

        assign rem_sh  = {p_rem, dbit};
        assign rem_sub = rem_sh - {1'b0, i_zr};
        assign qbit    = (rem_sh >= {1'b0, i_zr});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= qbit ? rem_sub[31:0] : rem_sh[31:0];
                r_q[i]   <= {p_q[LOG_D-2:0], qbit};
                r_abs[i] <= p_abs;
                r_vtx[i] <= p_vtx;
            end
        end
    end

    assign o_vld = r_vld[NW-1];
    assign o_q   = r_q[NW-1];
    assign o_vtx = r_vtx[NW-1];

endmodule

// ----- src/vdws_distort.sv -----
// vdws_distort: wave, squash and scale arithmetic, one multiply stage and one saturate stage each
// depends on vdws_pkg and vdws_sine_rom

module vdws_distort #(
    parameter int SINE_TABLE_DEPTH = vdws_pkg::SINE_DEPTH_DEF,
    parameter int FRACTION_BITS    = vdws_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] i_q,
    input  vdws_pkg::t_vtx                      i_vtx,
    input  vdws_pkg::t_cfg_flags                i_flags,
    input  logic signed [31:0]                  i_wave,
    input  logic signed [31:0]                  i_base,
    input  logic signed [FRACTION_BITS+2:0]     i_kx_sq,
    input  logic signed [FRACTION_BITS+2:0]     i_ky_sq,
    input  logic signed [FRACTION_BITS+2:0]     i_kxy,
    input  logic signed [FRACTION_BITS+2:0]     i_kz,
    output logic                                o_vld,
    output vdws_pkg::t_vtx                      o_vtx,
    output logic                                o_active
);
    import vdws_pkg::*;

    localparam int LOG_D = $clog2(SINE_TABLE_DEPTH);
    localparam int SW    = FRACTION_BITS + 2;
    localparam int KW    = FRACTION_BITS + 3;
    localparam int PW    = KW + 33;
    localparam logic [LOG_D-1:0] PHASE_OFS = LOG_D'(3 * (SINE_TABLE_DEPTH / 4));
    localparam logic signed [KW-1:0] ONE_K = KW'(1) <<< FRACTION_BITS;

    // stage 1: wave sine lookup
    logic [LOG_D-1:0]     idx;
    logic signed [SW-1:0] s_wave;
    logic                 r_v1;
    t_vtx                 r_vtx1;

    assign idx = i_q + PHASE_OFS;

    vdws_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_addr (idx),
        .o_data (s_wave)
    );

    // stage 2: wave product
    logic                 r_v2;
    t_vtx                 r_vtx2;
    logic signed [PW-1:0] r_pw;
    logic signed [KW-1:0] kw;
    assign kw = KW'(s_wave) + ONE_K;

    // stage 3: wave add
    logic                 r_v3;
    t_vtx                 r_vtx3;
    logic signed [31:0]   y3;
    assign y3 = (i_flags.wave_on && i_flags.wave_term_on)
              ? sat32(longint'(r_vtx2.y) + longint'(r_pw >>> FRACTION_BITS)) : r_vtx2.y;

    // stage 4: squash products
    logic                 r_v4;
    t_vtx                 r_vtx4;
    logic signed [PW-1:0] r_px4;
    logic signed [PW-1:0] r_py4;
    logic signed [32:0]   ydiff;
    assign ydiff = 33'(r_vtx3.y) - 33'(i_base);

    // stage 5: squash saturate
    logic                 r_v5;
    t_vtx                 r_vtx5;
    logic signed [31:0]   x5;
    logic signed [31:0]   y5;
    assign x5 = i_flags.squash_on ? sat32(longint'(r_px4 >>> FRACTION_BITS)) : r_vtx4.x;
    assign y5 = i_flags.squash_on
              ? sat32(longint'(r_py4 >>> FRACTION_BITS) + longint'(i_base)) : r_vtx4.y;

    // stage 6: scale products
    logic                 r_v6;
    t_vtx                 r_vtx6;
    logic signed [PW-1:0] r_px6;
    logic signed [PW-1:0] r_py6;
    logic signed [PW-1:0] r_pz6;

    // stage 7: scale saturate, output register
    logic                 r_v7;
    t_vtx                 r_vtx7;
    logic signed [31:0]   x7;
    logic signed [31:0]   y7;
    logic signed [31:0]   z7;
    assign x7 = i_flags.scale_on ? sat32(longint'(r_px6 >>> FRACTION_BITS)) : r_vtx6.x;
    assign y7 = i_flags.scale_on ? sat32(longint'(r_py6 >>> FRACTION_BITS)) : r_vtx6.y;
    assign z7 = i_flags.scale_on ? sat32(longint'(r_pz6 >>> FRACTION_BITS)) : r_vtx6.z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vtx1 <= i_vtx;

            r_vtx2 <= r_vtx1;
            r_pw   <= PW'(kw) * PW'(i_wave);

            r_vtx3 <= '{x: r_vtx2.x, y: y3, z: r_vtx2.z, last: r_vtx2.last};

            r_vtx4 <= r_vtx3;
            r_px4  <= PW'(i_kx_sq) * PW'(r_vtx3.x);
            r_py4  <= PW'(i_ky_sq) * PW'(ydiff);

            r_vtx5 <= '{x: x5, y: y5, z: r_vtx4.z, last: r_vtx4.last};

            r_vtx6 <= r_vtx5;
            r_px6  <= PW'(i_kxy) * PW'(r_vtx5.x);
            r_py6  <= PW'(i_kxy) * PW'(r_vtx5.y);
            r_pz6  <= PW'(i_kz) * PW'(r_vtx5.z);

            r_vtx7 <= '{x: x7, y: y7, z: z7, last: r_vtx6.last};
        end
    end

    assign o_vld    = r_v7;
    assign o_vtx    = r_vtx7;
    assign o_active = i_flags.wave_on | i_flags.squash_on | i_flags.scale_on;

endmodule

// ----- src/vertex_distort_wave_squash_scale.sv -----
// throughput: one vertex per cycle; the whole pipeline advances together and holds on stall
// the wave phase divider has one stage per dividend bit, 30 + log2(SINE_TABLE_DEPTH) stages
// reset: synchronous, active low; clears the configuration registers to zero and empties the pipeline
// depends on vdws_pkg, vdws_phase_div, vdws_distort and vdws_sine_rom

module vertex_distort_wave_squash_scale #(
    parameter int SINE_TABLE_DEPTH = vdws_pkg::SINE_DEPTH_DEF,  // power of two, 64 to 16384
    parameter int FRACTION_BITS    = vdws_pkg::FRAC_BITS_DEF    // 8 to 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input vertex beats
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // in_x, in_y, in_z
    input  logic         s_axis_tlast,   // last_vertex
    // output vertex beats
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // out_x, out_y, out_z
    output logic         m_axis_tlast,   // out_last
    output logic         m_axis_tuser    // any_stage_active
);
    import vdws_pkg::*;

    localparam int LOG_D = $clog2(SINE_TABLE_DEPTH);
    localparam int SW    = FRACTION_BITS + 2;
    localparam int KW    = FRACTION_BITS + 3;
    localparam int TENTH = ((1 << FRACTION_BITS) + 5) / 10;
    localparam logic signed [KW-1:0] ONE_K = KW'(1) <<< FRACTION_BITS;

    // configuration registers
    logic signed [31:0] r_wave, r_squash, r_scale, r_min_y, r_min_z, r_max_z;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave   <= '0;
            r_squash <= '0;
            r_scale  <= '0;
            r_min_y  <= '0;
            r_min_z  <= '0;
            r_max_z  <= '0;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_WAVE:   r_wave   <= pwdata;
                REG_SQUASH: r_squash <= pwdata;
                REG_SCALE:  r_scale  <= pwdata;
                REG_MIN_Y:  r_min_y  <= pwdata;
                REG_MIN_Z:  r_min_z  <= pwdata;
                REG_MAX_Z:  r_max_z  <= pwdata;
                default: ;  // unused addresses ignored
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_WAVE:   prdata = r_wave;
            REG_SQUASH: prdata = r_squash;
            REG_SCALE:  prdata = r_scale;
            REG_MIN_Y:  prdata = r_min_y;
            REG_MIN_Z:  prdata = r_min_z;
            REG_MAX_Z:  prdata = r_max_z;
            default:    prdata = '0;
        endcase
    end

    // derived coefficients, refreshed every cycle from the registers
    // r_zr is registered from them; the squash and scale factors also pass through a registered table read
    logic [31:0] abs_min_z, abs_max_z;
    logic [31:0] r_zr;
    assign abs_min_z = r_min_z[31] ? (~r_min_z + 32'd1) : r_min_z;
    assign abs_max_z = r_max_z[31] ? (~r_max_z + 32'd1) : r_max_z;

    // angle to table index: floor(quarter turns * D / 4) mod D
    logic signed [63:0] sq_m, sc_m;
    assign sq_m = (64'(r_squash) <<< LOG_D) >>> (FRACTION_BITS + 2);
    assign sc_m = (64'(r_scale)  <<< LOG_D) >>> (FRACTION_BITS + 2);

    logic signed [SW-1:0] s_sq, s_sc;

    vdws_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_rom_squash (
        .i_clk  (i_clk),
        .i_en   (1'b1),
        .i_addr (sq_m[LOG_D-1:0]),
        .o_data (s_sq)
    );

    vdws_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_rom_scale (
        .i_clk  (i_clk),
        .i_en   (1'b1),
        .i_addr (sc_m[LOG_D-1:0]),
        .o_data (s_sc)
    );

    logic signed [KW-1:0]            r_kx_sq, r_ky_sq, r_kxy, r_kz;
    logic signed [SW+FRACTION_BITS:0] tenth_p;
    assign tenth_p = (SW+FRACTION_BITS+1)'(s_sc) * (SW+FRACTION_BITS+1)'(TENTH);

    always_ff @(posedge i_clk) begin
        r_zr    <= (abs_min_z > abs_max_z) ? abs_min_z : abs_max_z;
        r_kx_sq <= ONE_K + KW'(s_sq);
        r_ky_sq <= ONE_K - KW'(s_sq);
        r_kxy   <= ONE_K + KW'(tenth_p >>> FRACTION_BITS);
        r_kz    <= ONE_K - KW'(s_sc);
    end

    t_cfg_flags flags;
    assign flags.wave_on      = (r_wave != '0);
    assign flags.wave_term_on = (r_zr != '0);
    assign flags.squash_on    = (r_squash != '0);
    assign flags.scale_on     = (r_scale != '0);

    // pipeline advance: the output register frees up or is being taken
    logic pipe_en;
    logic out_vld;
    assign pipe_en       = ~out_vld | m_axis_tready;
    assign s_axis_tready = pipe_en;

    t_vtx in_vtx;
    assign in_vtx.x    = s_axis_tdata[31:0];
    assign in_vtx.y    = s_axis_tdata[63:32];
    assign in_vtx.z    = s_axis_tdata[95:64];
    assign in_vtx.last = s_axis_tlast;

    // wave phase: floor(|z| * D / (4 * zrange)), low bits only
    logic             div_vld;
    logic [LOG_D-1:0] div_q;
    t_vtx             div_vtx;

    vdws_phase_div #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (s_axis_tvalid),
        .i_vtx   (in_vtx),
        .i_zr    (r_zr),
        .o_vld   (div_vld),
        .o_q     (div_q),
        .o_vtx   (div_vtx)
    );

    t_vtx out_vtx;
    logic out_active;

    vdws_distort #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_distort (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_vld    (div_vld),
        .i_q      (div_q),
        .i_vtx    (div_vtx),
        .i_flags  (flags),
        .i_wave   (r_wave),
        .i_base   (r_min_y),
        .i_kx_sq  (r_kx_sq),
        .i_ky_sq  (r_ky_sq),
        .i_kxy    (r_kxy),
        .i_kz     (r_kz),
        .o_vld    (out_vld),
        .o_vtx    (out_vtx),
        .o_active (out_active)
    );

    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata  = {out_vtx.z, out_vtx.y, out_vtx.x};
    assign m_axis_tlast  = out_vtx.last;
    assign m_axis_tuser  = out_active;

`ifndef SYNTHESIS
    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid right after reset");

    // input is taken exactly when the pipeline can advance
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // the active flag reflects the amount registers
    a_active_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (r_wave != 0 || r_squash != 0 || r_scale != 0)))
        else $error("stage active flag disagrees with amount registers");
`endif

endmodule
